@@ design/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg
// Shared constants, types and helpers of the retransmit tracker.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PTR_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int RESULT_LIMIT  = 8;
    localparam int CNT_W         = $clog2(RESULT_LIMIT + 1);
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_AW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam int OPCODE_W  = 2;
    localparam int TIME_W    = 32;
    localparam int SEQ_W     = 8;
    localparam int MAC_W     = 48;
    localparam int LEN_W     = 8;
    localparam int KIND_W    = 2;
    localparam int SLOTOUT_W = 3;
    localparam int RETRY_W   = 8;
    localparam int TMO_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [TMO_W-1:0]     TIMEOUT_RESET = 16'd500;
    localparam logic [RETRY_W-1:0]   RETRIES_RESET = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRIES   = 8'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TRACK = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        EV_STORED  = 2'd0,
        EV_FULL    = 2'd1,
        EV_RESEND  = 2'd2,
        EV_GAVE_UP = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        opcode_t           op;
        logic [TIME_W-1:0] now;
        logic [SEQ_W-1:0]  seq;
        logic [MAC_W-1:0]  mac;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        event_kind_t          kind;
        logic [SLOTOUT_W-1:0] slot;
        logic [SEQ_W-1:0]     seq;
        logic [MAC_W-1:0]     mac;
        logic [LEN_W-1:0]     len;
        logic [RETRY_W-1:0]   retries;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [TMO_W-1:0]   timeout_ms;
        logic [RETRY_W-1:0] max_retries;
    } cfg_t;

    function automatic logic [SLOTOUT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOTOUT_W-1:0];
    endfunction

endpackage

@@ design/art_if.sv @@
// ----------------------------------------------------------------------------
// art_if
// Handshake channels of the retransmit tracker: items, results, register writes.
// ----------------------------------------------------------------------------
interface art_item_if
    import art_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [TIME_W-1:0]   now_ms;
    logic [SEQ_W-1:0]    seq_number;
    logic [MAC_W-1:0]    dest_mac;
    logic [LEN_W-1:0]    frame_length;

    modport source (output valid, opcode, now_ms, seq_number, dest_mac, frame_length,
                    input ready);
    modport sink   (input valid, opcode, now_ms, seq_number, dest_mac, frame_length,
                    output ready);
endinterface

interface art_result_if
    import art_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    event_kind;
    logic [SLOTOUT_W-1:0] slot_index;
    logic [SEQ_W-1:0]     result_seq;
    logic [MAC_W-1:0]     result_mac;
    logic [LEN_W-1:0]     result_length;
    logic [RETRY_W-1:0]   retry_count;
    logic                 last_result;

    modport source (output valid, event_kind, slot_index, result_seq, result_mac,
                    result_length, retry_count, last_result, input ready);
    modport sink   (input valid, event_kind, slot_index, result_seq, result_mac,
                    result_length, retry_count, last_result, output ready);
endinterface

interface art_cfg_if
    import art_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/art_front.sv @@
// ----------------------------------------------------------------------------
// art_front
// Accept item beats, decode the opcode and queue valid commands.
// ----------------------------------------------------------------------------
module art_front
    import art_pkg::*;
(
    art_item_if.sink item,
    input  logic     queue_full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic op_known;

    always_comb
    begin
        case (item.opcode)
            OP_TRACK, OP_ACK, OP_TICK: op_known = 1'b1;
            default:                   op_known = 1'b0;
        endcase
    end

    assign item.ready   = !queue_full;
    assign push         = item.valid && !queue_full && op_known;
    assign push_cmd.op  = opcode_t'(item.opcode);
    assign push_cmd.now = item.now_ms;
    assign push_cmd.seq = item.seq_number;
    assign push_cmd.mac = item.dest_mac;
    assign push_cmd.len = item.frame_length;

endmodule

@@ design/art_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// art_cmd_fifo
// Short command queue between the front and the table engine.
// ----------------------------------------------------------------------------
module art_cmd_fifo
    import art_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic head_valid
);

    cmd_t               store_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign full       = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/art_back.sv @@
// ----------------------------------------------------------------------------
// art_back
// Slot table engine: store, free and scan slots, and drive result beats.
// ----------------------------------------------------------------------------
module art_back
    import art_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           cmd_valid,
    input  cmd_t           cmd,
    output logic           cmd_pop,
    art_result_if.source   result
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [TABLE_ENTRIES-1:0] active_reg;
    logic [SEQ_W-1:0]         seq_mem     [TABLE_ENTRIES];
    logic [RETRY_W-1:0]       retries_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0]        sent_mem    [TABLE_ENTRIES];
    logic [MAC_W-1:0]         mac_mem     [TABLE_ENTRIES];
    logic [LEN_W-1:0]         len_mem     [TABLE_ENTRIES];

    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pend_valid_reg;
    result_t          pend_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic              out_space;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              match_found;
    logic [SLOT_W-1:0] match_idx;
    logic [SLOT_W-1:0] ptr_idx;
    logic              scan_end;
    logic [TIME_W-1:0] elapsed;
    logic              hit;
    logic              give_up;
    logic              scan_go;
    logic [RETRY_W-1:0] retries_inc;
    result_t           track_result;
    result_t           hit_result;

    logic    do_track;
    logic    do_ack;
    logic    start_scan;
    logic    scan_step;
    logic    scan_hit;
    logic    flush_done;
    logic    out_load;
    result_t out_data;

    assign out_space = !out_valid_reg || result.ready;

    always_comb
    begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (active_reg[i] && (seq_mem[i] == cmd.seq))
            begin
                match_found = 1'b1;
                match_idx   = SLOT_W'(i);
            end
        end
    end

    assign ptr_idx     = ptr_reg[SLOT_W-1:0];
    assign scan_end    = (ptr_reg == PTR_W'(TABLE_ENTRIES)) || (cnt_reg == CNT_W'(RESULT_LIMIT));
    assign elapsed     = cmd.now - sent_mem[ptr_idx];
    assign hit         = active_reg[ptr_idx] && (elapsed >= TIME_W'(cfg.timeout_ms));
    assign give_up     = (retries_mem[ptr_idx] >= cfg.max_retries);
    assign scan_go     = !hit || !pend_valid_reg || out_space;
    assign retries_inc = retries_mem[ptr_idx] + 1'b1;

    always_comb
    begin
        track_result.slot    = '0;
        track_result.seq     = cmd.seq;
        track_result.retries = '0;
        track_result.last    = 1'b1;
        if (free_found)
        begin
            track_result.kind = EV_STORED;
            track_result.slot = slot_field(free_idx);
            track_result.mac  = cmd.mac;
            track_result.len  = cmd.len;
        end
        else
        begin
            track_result.kind = EV_FULL;
            track_result.mac  = '0;
            track_result.len  = '0;
        end
    end

    always_comb
    begin
        hit_result.kind    = give_up ? EV_GAVE_UP : EV_RESEND;
        hit_result.slot    = slot_field(ptr_idx);
        hit_result.seq     = seq_mem[ptr_idx];
        hit_result.mac     = mac_mem[ptr_idx];
        hit_result.len     = len_mem[ptr_idx];
        hit_result.retries = give_up ? retries_mem[ptr_idx] : retries_inc;
        hit_result.last    = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_space)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        do_track   = 1'b0;
        do_ack     = 1'b0;
        start_scan = 1'b0;
        scan_step  = 1'b0;
        flush_done = 1'b0;
        cmd_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_TRACK:
                        begin
                            do_track = out_space;
                            cmd_pop  = out_space;
                        end
                        OP_ACK:
                        begin
                            do_ack  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        OP_TICK:
                        begin
                            start_scan = 1'b1;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_step = !scan_end && scan_go;
            end
            ST_FLUSH:
            begin
                flush_done = !pend_valid_reg || out_space;
                cmd_pop    = flush_done;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    assign scan_hit = scan_step && hit;

    always_comb
    begin
        out_load = 1'b0;
        out_data = pend_reg;
        if (do_track)
        begin
            out_load = 1'b1;
            out_data = track_result;
        end
        else if (scan_hit && pend_valid_reg)
        begin
            out_load      = 1'b1;
            out_data.last = 1'b0;
        end
        else if (flush_done && pend_valid_reg)
        begin
            out_load      = 1'b1;
            out_data.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            ptr_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_track && free_found)
            begin
                active_reg[free_idx] <= 1'b1;
            end
            if (do_ack && match_found)
            begin
                active_reg[match_idx] <= 1'b0;
            end
            if (scan_hit && give_up)
            begin
                active_reg[ptr_idx] <= 1'b0;
            end
            if (start_scan)
            begin
                ptr_reg <= '0;
                cnt_reg <= '0;
            end
            else if (scan_step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                if (hit)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (scan_hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush_done)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_track && free_found)
        begin
            seq_mem[free_idx]     <= cmd.seq;
            retries_mem[free_idx] <= '0;
            sent_mem[free_idx]    <= cmd.now;
            mac_mem[free_idx]     <= cmd.mac;
            len_mem[free_idx]     <= cmd.len;
        end
        if (scan_hit && !give_up)
        begin
            retries_mem[ptr_idx] <= retries_inc;
            sent_mem[ptr_idx]    <= cmd.now;
        end
        if (scan_hit)
        begin
            pend_reg <= hit_result;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.event_kind    = out_reg.kind;
    assign result.slot_index    = out_reg.slot;
    assign result.result_seq    = out_reg.seq;
    assign result.result_mac    = out_reg.mac;
    assign result.result_length = out_reg.len;
    assign result.retry_count   = out_reg.retries;
    assign result.last_result   = out_reg.last;

endmodule

@@ design/ack_retransmit_tracker.sv @@
// ----------------------------------------------------------------------------
// ack_retransmit_tracker
// Retransmit timeout table for frames that await an acknowledgement.
//
//   port    | dir  | carries
//   --------+------+----------------------------------------------------
//   item    | sink | opcode, now_ms, seq_number, dest_mac, frame_length
//   result  | src  | event_kind, slot_index, result_seq, result_mac,
//           |      | result_length, retry_count, last_result
//   cfg     | sink | index (0 timeout_ms, 1 max_retries), data
//
// Item beats enter a two-deep command queue, one per cycle while it has room.
// A tick starts, then walks the slots one per cycle through the shared expiry
// compare while a hit finds room for its pending result, stops at the last slot
// or the result limit, and flushes the last pending result.
// The engine stalls on a full result register and resumes without loss.
// Reset clears all slots and loads timeout_ms 500 and max_retries 3.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker
    import art_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    art_item_if.sink      item,
    art_result_if.source  result,
    art_cfg_if.sink       cfg
);

    cfg_t cfg_reg;
    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic cmd_pop;
    cmd_t head_cmd;
    logic head_valid;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms  <= TIMEOUT_RESET;
            cfg_reg.max_retries <= RETRIES_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_TIMEOUT)
            begin
                cfg_reg.timeout_ms <= cfg.data;
            end
            if (cfg.index == REG_RETRIES)
            begin
                cfg_reg.max_retries <= cfg.data[RETRY_W-1:0];
            end
        end
    end

    art_front u_front (
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    art_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (cmd_pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    art_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .result    (result)
    );

endmodule

@@ dv/ack_retransmit_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_tb
// Self-checking bench for the retransmit timeout table. Runs a directed
// sequence (table full, duplicate seqs, timer wrap, eight-result ticks,
// timeout zero, give-up) and then random track/ack/tick traffic under
// several register settings. Every result beat is checked against an
// in-bench model of the slot table.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_tb;
    import art_pkg::*;

    localparam logic [OPCODE_W-1:0]  OP_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = 8'hFF;
    localparam int                   SETTLE_CYCLES  = 4 * (TABLE_ENTRIES + 2);
    localparam int                   WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [TIME_W-1:0]   now_ms;
        logic [SEQ_W-1:0]    seq_number;
        logic [MAC_W-1:0]    dest_mac;
        logic [LEN_W-1:0]    frame_length;
    } tracker_cmd_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;

    art_item_if   item_ch ();
    art_result_if res_ch ();
    art_cfg_if    cfg_ch ();

    ack_retransmit_tracker DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    tracker_cmd_t pending_cmds[$];
    reg_write_t   reg_writes[$];
    result_t      expected_events[$];
    logic [SEQ_W-1:0] recent_seqs[$];

    tracker_cmd_t drive_cmd;
    reg_write_t   drive_write;
    result_t      want_event;
    logic [TIME_W-1:0] traffic_ms;
    int gap_pct = 31;
    int mismatches = 0;
    int quiet_cycles = 0;

    logic [TMO_W-1:0]   timeout_reg;
    logic [RETRY_W-1:0] retries_reg;
    logic               slot_busy  [TABLE_ENTRIES];
    logic [SEQ_W-1:0]   slot_seq   [TABLE_ENTRIES];
    logic [RETRY_W-1:0] slot_tries [TABLE_ENTRIES];
    logic [TIME_W-1:0]  slot_time  [TABLE_ENTRIES];
    logic [MAC_W-1:0]   slot_mac   [TABLE_ENTRIES];
    logic [LEN_W-1:0]   slot_len   [TABLE_ENTRIES];

    function automatic void predict_table_events(input tracker_cmd_t c);
        result_t r;
        result_t batch[$];
        int      found;
        logic [TIME_W-1:0] age;
        found = -1;
        r = '0;
        if (c.opcode == OP_TRACK) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!slot_busy[i] && found < 0)
                    found = i;
            r.seq  = c.seq_number;
            r.last = 1'b1;
            if (found >= 0) begin
                slot_busy[found]  = 1'b1;
                slot_seq[found]   = c.seq_number;
                slot_tries[found] = '0;
                slot_time[found]  = c.now_ms;
                slot_mac[found]   = c.dest_mac;
                slot_len[found]   = c.frame_length;
                r.kind = EV_STORED;
                r.slot = SLOTOUT_W'(found);
                r.mac  = c.dest_mac;
                r.len  = c.frame_length;
            end
            else
                r.kind = EV_FULL;
            expected_events.push_back(r);
        end
        else if (c.opcode == OP_ACK) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (found < 0 && slot_busy[i] && slot_seq[i] == c.seq_number)
                    found = i;
            if (found >= 0)
                slot_busy[found] = 1'b0;
        end
        else if (c.opcode == OP_TICK) begin
            for (int i = 0; i < TABLE_ENTRIES && batch.size() < RESULT_LIMIT; i++) begin
                age = c.now_ms - slot_time[i];
                if (slot_busy[i] && age >= TIME_W'(timeout_reg)) begin
                    r.slot = SLOTOUT_W'(i);
                    r.seq  = slot_seq[i];
                    r.mac  = slot_mac[i];
                    r.len  = slot_len[i];
                    r.last = 1'b0;
                    if (slot_tries[i] >= retries_reg) begin
                        slot_busy[i] = 1'b0;
                        r.kind = EV_GAVE_UP;
                    end
                    else begin
                        slot_tries[i] = slot_tries[i] + 1'b1;
                        slot_time[i]  = c.now_ms;
                        r.kind = EV_RESEND;
                    end
                    r.retries = slot_tries[i];
                    batch.push_back(r);
                end
            end
            if (batch.size() != 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k])
                expected_events.push_back(batch[k]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_cmd(input logic [OPCODE_W-1:0] op,
                                     input logic [TIME_W-1:0] now,
                                     input logic [SEQ_W-1:0] seq,
                                     input logic [MAC_W-1:0] mac,
                                     input logic [LEN_W-1:0] len);
        tracker_cmd_t c;
        c.opcode       = op;
        c.now_ms       = now;
        c.seq_number   = seq;
        c.dest_mac     = mac;
        c.frame_length = len;
        pending_cmds.push_back(c);
    endfunction

    function automatic void push_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DAT_W-1:0] value);
        reg_write_t w;
        w.index = idx;
        w.data  = value;
        reg_writes.push_back(w);
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || item_ch.valid || reg_writes.size() != 0
               || cfg_ch.valid || expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_traffic(input int count, input int tmo);
        int pick;
        logic [SEQ_W-1:0] seq;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            seq = ($urandom_range(0, 9) < 3) ? SEQ_W'($urandom_range(0, 3)) : SEQ_W'($urandom);
            if (pick < 40) begin
                traffic_ms += 32'($urandom_range(0, tmo / 4));
                push_cmd(OP_TRACK, traffic_ms, seq, MAC_W'({$urandom, $urandom}),
                         LEN_W'($urandom));
                recent_seqs.push_back(seq);
                if (recent_seqs.size() > 16)
                    recent_seqs.delete(0);
            end
            else if (pick < 65) begin
                if (recent_seqs.size() != 0 && $urandom_range(0, 4) != 0)
                    seq = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
                push_cmd(OP_ACK, $urandom, seq, MAC_W'({$urandom, $urandom}),
                         LEN_W'($urandom));
            end
            else if (pick < 92) begin
                traffic_ms += 32'($urandom_range(0, tmo + tmo / 2 + 1));
                push_cmd(OP_TICK, traffic_ms, seq, MAC_W'({$urandom, $urandom}),
                         LEN_W'($urandom));
            end
            else if (pick < 96)
                push_cmd(OP_UNUSED, $urandom, seq, MAC_W'({$urandom, $urandom}),
                         LEN_W'($urandom));
            else
                push_cmd(OP_TICK, $urandom, seq, MAC_W'({$urandom, $urandom}),
                         LEN_W'($urandom));
        end
    endtask

    task automatic run_phase(input int tmo, input int tries, input int count,
                             input logic [TIME_W-1:0] start_ms, input int gaps);
        push_reg(REG_TIMEOUT, CFG_DAT_W'(tmo));
        push_reg(REG_RETRIES, {8'($urandom), RETRY_W'(tries)});
        wait_drained();
        gap_pct    = gaps;
        traffic_ms = start_ms;
        queue_traffic(count, tmo);
        wait_drained();
        gap_pct = 31;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hold the valid of a beat until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                drive_cmd = pending_cmds.pop_front();
                item_ch.valid        <= 1'b1;
                item_ch.opcode       <= drive_cmd.opcode;
                item_ch.now_ms       <= drive_cmd.now_ms;
                item_ch.seq_number   <= drive_cmd.seq_number;
                item_ch.dest_mac     <= drive_cmd.dest_mac;
                item_ch.frame_length <= drive_cmd.frame_length;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_ch.valid <= 1'b0;
        else if (!cfg_ch.valid || cfg_ch.ready)
        begin
            if (reg_writes.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                drive_write = reg_writes.pop_front();
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= drive_write.index;
                cfg_ch.data  <= drive_write.data;
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result beat with no expectation: kind %0d slot %0d seq 'h%0h",
                           res_ch.event_kind, res_ch.slot_index, res_ch.result_seq);
                    mismatches++;
                end
                else
                begin
                    want_event = expected_events.pop_front();
                    check_field("event_kind", want_event.kind, res_ch.event_kind);
                    check_field("slot_index", want_event.slot, res_ch.slot_index);
                    check_field("result_seq", want_event.seq, res_ch.result_seq);
                    check_field("result_mac", want_event.mac, res_ch.result_mac);
                    check_field("result_length", want_event.len, res_ch.result_length);
                    check_field("retry_count", want_event.retries, res_ch.retry_count);
                    check_field("last_result", want_event.last, res_ch.last_result);
                end
            end
            if (item_ch.valid && item_ch.ready)
                predict_table_events({item_ch.opcode, item_ch.now_ms, item_ch.seq_number,
                                      item_ch.dest_mac, item_ch.frame_length});
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_TIMEOUT: timeout_reg = cfg_ch.data;
                    REG_RETRIES: retries_reg = cfg_ch.data[RETRY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ack_retransmit_tracker regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.opcode       = '0;
        item_ch.now_ms       = '0;
        item_ch.seq_number   = '0;
        item_ch.dest_mac     = '0;
        item_ch.frame_length = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        res_ch.ready         = 1'b0;
        traffic_ms           = '0;
        timeout_reg          = TIMEOUT_RESET;
        retries_reg          = RETRIES_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_busy[i]  = 1'b0;
            slot_seq[i]   = '0;
            slot_tries[i] = '0;
            slot_time[i]  = '0;
            slot_mac[i]   = '0;
            slot_len[i]   = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty table, fill, full, duplicate seqs, wrap, give-up
        push_cmd(OP_TICK, 32'd0, 8'h00, '0, '0);
        push_cmd(OP_ACK, 32'd0, 8'h55, '0, '0);
        push_cmd(OP_UNUSED, '1, '1, '1, '1);
        push_cmd(OP_TRACK, 32'd0, 8'h00, '0, '0);
        push_cmd(OP_TRACK, 32'hFFFF_FFFF, 8'hFF, '1, 8'hFF);
        for (int k = 0; k < 6; k++)
            push_cmd(OP_TRACK, 32'd100, (k < 2) ? 8'h07 : SEQ_W'(8'h10 + k),
                     48'hA5A5_0000_0000 | MAC_W'(k), LEN_W'(8'h40 + k));
        push_cmd(OP_TRACK, 32'd150, 8'h99, 48'h1234_5678_9ABC, 8'h22);
        push_cmd(OP_ACK, 32'd160, 8'h07, '0, '0);
        push_cmd(OP_TRACK, 32'd200, 8'h21, 48'h0000_5A5A_5A5A, 8'h01);
        push_cmd(OP_TICK, 32'd499, 8'h00, '0, '0);
        push_cmd(OP_TICK, 32'd1000, 8'h00, '0, '0);
        push_cmd(OP_TICK, 32'd1500, 8'h00, '0, '0);
        push_cmd(OP_TICK, 32'd2000, 8'h00, '0, '0);
        push_cmd(OP_TICK, 32'd2500, 8'h00, '0, '0);
        push_cmd(OP_TICK, 32'd3000, 8'h00, '0, '0);
        push_cmd(OP_ACK, 32'd3000, 8'hFF, '0, '0);
        wait_drained();

        // timeout zero, no retries; spare register indexes are ignored
        push_reg(REG_SPARE_LO, 16'hFFFF);
        push_reg(REG_SPARE_HI, 16'h1234);
        push_reg(REG_TIMEOUT, 16'd0);
        push_reg(REG_RETRIES, 16'hFF00);
        wait_drained();
        push_cmd(OP_TRACK, 32'h8000_0000, 8'h03, 48'h0000_0000_0001, 8'h10);
        push_cmd(OP_TRACK, 32'd5, 8'h04, 48'h8000_0000_0000, 8'h80);
        push_cmd(OP_TICK, 32'd5, 8'h00, '0, '0);
        push_cmd(OP_TRACK, 32'd7, 8'h05, 48'h0F0F_0F0F_0F0F, 8'h0F);
        push_cmd(OP_ACK, 32'd7, 8'h05, '0, '0);
        push_cmd(OP_TICK, 32'd7, 8'h00, '0, '0);
        wait_drained();

        run_phase(1, 255, 60, 32'd0, 31);
        run_phase(65535, 0, 60, $urandom, 31);
        run_phase(300, 2, 70, 32'hFFFF_FE00, 0);
        run_phase($urandom_range(1, 2000), $urandom_range(0, 5), 60, $urandom, 31);

        if (mismatches == 0)
            $display("ack_retransmit_tracker regression: pass");
        else
            $display("ack_retransmit_tracker regression: fail");
        $finish;
    end

endmodule
